// ===== rtl/abac_pkg.sv =====
// Shared types, constants and helper functions of the alpha bounding box autocrop block.
package abac_pkg;

    localparam int unsigned MAX_DIMENSION = 4096;
    localparam int unsigned COORD_W       = 12;
    localparam int unsigned DIM_W         = 13;
    localparam int unsigned ALPHA_W       = 8;
    localparam int unsigned PAD_W         = 7;
    localparam int unsigned CFG_IDX_W     = 2;
    localparam int unsigned CFG_DATA_W    = 13;

    // The padding is (2m + 50) / 100, with the division done as a multiply by
    // 5243 / 2^19, which is exact for every dividend below 43690.
    localparam int unsigned NUMER_W     = 14;
    localparam int unsigned RECIP_MUL   = 5243;
    localparam int unsigned RECIP_SHIFT = 19;
    localparam int unsigned PROD_W      = 27;
    localparam int unsigned ROUND_BIAS  = 50;
    localparam int unsigned PAD_MIN     = 2;

    typedef logic [COORD_W-1:0]    coord_t;
    typedef logic [DIM_W-1:0]      dim_t;
    typedef logic [ALPHA_W-1:0]    alpha_t;
    typedef logic [PAD_W-1:0]      pad_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_index_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH     = 2'd0,
        CFG_IMAGE_HEIGHT    = 2'd1,
        CFG_ALPHA_THRESHOLD = 2'd2
    } cfg_reg_t;

    localparam dim_t   WIDTH_RESET     = 13'd640;
    localparam dim_t   HEIGHT_RESET    = 13'd480;
    localparam alpha_t THRESHOLD_RESET = 8'd2;

    typedef struct packed {
        coord_t left;
        coord_t right;
        coord_t top;
        coord_t bottom;
        logic   found;
        dim_t   width;
        dim_t   height;
    } frame_box_t;

    function automatic dim_t eff_dim(dim_t v);
        dim_t r;
        if (v == '0)
        begin
            r = dim_t'(1);
        end
        else if (v > dim_t'(MAX_DIMENSION))
        begin
            r = dim_t'(MAX_DIMENSION);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    function automatic coord_t last_coord(dim_t v);
        dim_t d;
        d = v - dim_t'(1);
        return d[COORD_W-1:0];
    endfunction

endpackage

// ===== rtl/abac_ifs.sv =====
// Handshake channel interfaces for pixels, crop results and configuration writes.
interface abac_pix_if;
    import abac_pkg::*;
    logic   valid;
    logic   ready;
    alpha_t pixel_alpha;
    modport source (output valid, output pixel_alpha, input ready);
    modport sink (input valid, input pixel_alpha, output ready);
endinterface

interface abac_crop_if;
    import abac_pkg::*;
    logic   valid;
    logic   ready;
    coord_t crop_x;
    coord_t crop_y;
    dim_t   crop_width;
    dim_t   crop_height;
    logic   content_found;
    modport source (output valid, output crop_x, output crop_y, output crop_width,
                    output crop_height, output content_found, input ready);
    modport sink (input valid, input crop_x, input crop_y, input crop_width,
                  input crop_height, input content_found, output ready);
endinterface

interface abac_cfg_if;
    import abac_pkg::*;
    logic       valid;
    logic       ready;
    cfg_index_t index;
    cfg_data_t  data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/abac_track.sv =====
// Raster position counters and bounding box tracking, with frame-end box capture.
module abac_track (
    input  logic                clk,
    input  logic                rst_n,
    input  abac_pkg::dim_t      width,
    input  abac_pkg::dim_t      height,
    input  abac_pkg::alpha_t    threshold,
    abac_pix_if.sink            pixel,
    output logic                box_valid,
    output abac_pkg::frame_box_t box,
    input  logic                box_ready
);
    import abac_pkg::*;

    coord_t     col_reg, col_next;
    coord_t     row_reg, row_next;
    coord_t     left_reg, left_next;
    coord_t     top_reg, top_next;
    coord_t     right_reg, right_next;
    coord_t     bottom_reg, bottom_next;
    logic       found_reg, found_next;
    logic       box_valid_reg, box_valid_next;
    frame_box_t box_reg, box_next;

    coord_t col_last_idx;
    coord_t row_last_idx;
    logic   hit;
    logic   col_last;
    logic   frame_last;
    logic   cap_ready;
    logic   accept;
    coord_t left_upd, top_upd, right_upd, bottom_upd;
    logic   found_upd;

    always_comb
    begin
        col_last_idx = last_coord(width);
        row_last_idx = last_coord(height);
        hit          = pixel.pixel_alpha > threshold;
        col_last     = col_reg >= col_last_idx;
        frame_last   = col_last && (row_reg >= row_last_idx);
        cap_ready    = !box_valid_reg || box_ready;
        pixel.ready  = !frame_last || cap_ready;
        accept       = pixel.valid && pixel.ready;

        left_upd   = (hit && col_reg < left_reg)   ? col_reg : left_reg;
        top_upd    = (hit && row_reg < top_reg)    ? row_reg : top_reg;
        right_upd  = (hit && col_reg > right_reg)  ? col_reg : right_reg;
        bottom_upd = (hit && row_reg > bottom_reg) ? row_reg : bottom_reg;
        found_upd  = found_reg || hit;

        col_next       = col_reg;
        row_next       = row_reg;
        left_next      = left_reg;
        top_next       = top_reg;
        right_next     = right_reg;
        bottom_next    = bottom_reg;
        found_next     = found_reg;
        box_valid_next = box_valid_reg && !box_ready;
        box_next       = box_reg;

        if (accept)
        begin
            if (frame_last)
            begin
                col_next       = '0;
                row_next       = '0;
                left_next      = '1;
                top_next       = '1;
                right_next     = '0;
                bottom_next    = '0;
                found_next     = 1'b0;
                box_valid_next = 1'b1;
                box_next       = '{left: left_upd, right: right_upd, top: top_upd,
                                   bottom: bottom_upd, found: found_upd,
                                   width: width, height: height};
            end
            else
            begin
                col_next    = col_last ? '0 : col_reg + coord_t'(1);
                row_next    = col_last ? row_reg + coord_t'(1) : row_reg;
                left_next   = left_upd;
                top_next    = top_upd;
                right_next  = right_upd;
                bottom_next = bottom_upd;
                found_next  = found_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            left_reg      <= '1;
            top_reg       <= '1;
            right_reg     <= '0;
            bottom_reg    <= '0;
            found_reg     <= 1'b0;
            box_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            left_reg      <= left_next;
            top_reg       <= top_next;
            right_reg     <= right_next;
            bottom_reg    <= bottom_next;
            found_reg     <= found_next;
            box_valid_reg <= box_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        box_reg <= box_next;
    end

    assign box_valid = box_valid_reg;
    assign box       = box_reg;

endmodule

// ===== rtl/abac_crop.sv =====
// Crop rectangle pipeline: box clamp, padding computation and padded, clamped output.
module abac_crop (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 box_valid,
    input  abac_pkg::frame_box_t box,
    output logic                 box_ready,
    abac_crop_if.source          result
);
    import abac_pkg::*;

    logic       s2_valid_reg, s2_valid_next;
    frame_box_t s2_box_reg, s2_box_next;
    dim_t       s2_span_reg, s2_span_next;
    logic       s3_valid_reg, s3_valid_next;
    frame_box_t s3_box_reg, s3_box_next;
    pad_t       s3_pad_reg, s3_pad_next;
    logic       out_valid_reg, out_valid_next;
    coord_t     x_reg, x_next;
    coord_t     y_reg, y_next;
    dim_t       cw_reg, cw_next;
    dim_t       ch_reg, ch_next;
    logic       found_reg, found_next;

    logic                out_ready, s3_ready, s2_ready;
    coord_t              col_lim, row_lim;
    dim_t                box_w, box_h;
    logic [NUMER_W-1:0]  numer;
    logic [PROD_W-1:0]   prod;
    logic [PROD_W-1:0]   quot;
    pad_t                pad_raw;
    coord_t              pad_c;
    dim_t                pad_d;
    dim_t                right_end, bottom_end;

    always_comb
    begin
        out_ready = !out_valid_reg || result.ready;
        s3_ready  = !s3_valid_reg || out_ready;
        s2_ready  = !s2_valid_reg || s3_ready;
        box_ready = s2_ready;

        s2_valid_next  = s2_ready ? box_valid : s2_valid_reg;
        s3_valid_next  = s3_ready ? s2_valid_reg : s3_valid_reg;
        out_valid_next = out_ready ? s3_valid_reg : out_valid_reg;

        // Clamp the box to the frame and find its larger side.
        col_lim             = last_coord(box.width);
        row_lim             = last_coord(box.height);
        s2_box_next         = box;
        s2_box_next.left    = (box.left < col_lim) ? box.left : col_lim;
        s2_box_next.right   = (box.right < col_lim) ? box.right : col_lim;
        s2_box_next.top     = (box.top < row_lim) ? box.top : row_lim;
        s2_box_next.bottom  = (box.bottom < row_lim) ? box.bottom : row_lim;
        box_w = dim_t'(s2_box_next.right) - dim_t'(s2_box_next.left) + dim_t'(1);
        box_h = dim_t'(s2_box_next.bottom) - dim_t'(s2_box_next.top) + dim_t'(1);
        s2_span_next = (box_w > box_h) ? box_w : box_h;

        // Padding is the rounded two percent of the larger side, at least two.
        numer       = {s2_span_reg, 1'b0} + NUMER_W'(ROUND_BIAS);
        prod        = PROD_W'(numer) * PROD_W'(RECIP_MUL);
        quot        = prod >> RECIP_SHIFT;
        pad_raw     = quot[PAD_W-1:0];
        s3_pad_next = (pad_raw < pad_t'(PAD_MIN)) ? pad_t'(PAD_MIN) : pad_raw;
        s3_box_next = s2_box_reg;

        pad_c      = coord_t'(s3_pad_reg);
        pad_d      = dim_t'(s3_pad_reg);
        right_end  = dim_t'(s3_box_reg.right) + pad_d + dim_t'(1);
        bottom_end = dim_t'(s3_box_reg.bottom) + pad_d + dim_t'(1);
        right_end  = (right_end > s3_box_reg.width) ? s3_box_reg.width : right_end;
        bottom_end = (bottom_end > s3_box_reg.height) ? s3_box_reg.height : bottom_end;
        found_next = s3_box_reg.found;
        if (s3_box_reg.found)
        begin
            x_next  = (s3_box_reg.left > pad_c) ? s3_box_reg.left - pad_c : '0;
            y_next  = (s3_box_reg.top > pad_c) ? s3_box_reg.top - pad_c : '0;
            cw_next = right_end - dim_t'(x_next);
            ch_next = bottom_end - dim_t'(y_next);
        end
        else
        begin
            x_next  = '0;
            y_next  = '0;
            cw_next = s3_box_reg.width;
            ch_next = s3_box_reg.height;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready)
        begin
            s2_box_reg  <= s2_box_next;
            s2_span_reg <= s2_span_next;
        end
        if (s3_ready)
        begin
            s3_box_reg <= s3_box_next;
            s3_pad_reg <= s3_pad_next;
        end
        if (out_ready)
        begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            cw_reg    <= cw_next;
            ch_reg    <= ch_next;
            found_reg <= found_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.crop_x        = x_reg;
    assign result.crop_y        = y_reg;
    assign result.crop_width    = cw_reg;
    assign result.crop_height   = ch_reg;
    assign result.content_found = found_reg;

endmodule

// ===== rtl/alpha_bbox_autocrop_core.sv =====
// Top level of the alpha bounding box autocrop block with its configuration registers.
// Throughput: one pixel per clock while the last pixel of a frame is not held back by an
// untaken box; the position counters and box update are registered. A frame's crop result
// passes box capture, clamp stage, padding multiply stage and output, and can be stalled.
// Reset: rst_n clears the position, the box and all pipeline valids at once and loads
// width 640, height 480 and threshold 2; no clearing pass is needed.
module alpha_bbox_autocrop_core (
    input  logic        clk,
    input  logic        rst_n,
    abac_pix_if.sink    pixel,
    abac_crop_if.source result,
    abac_cfg_if.sink    cfg
);
    import abac_pkg::*;

    dim_t       width_reg, width_next;
    dim_t       height_reg, height_next;
    alpha_t     thresh_reg, thresh_next;
    dim_t       eff_width, eff_height;
    logic       box_valid;
    logic       box_ready;
    frame_box_t box;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        thresh_next = thresh_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_IMAGE_WIDTH:     width_next  = cfg.data;
                CFG_IMAGE_HEIGHT:    height_next = cfg.data;
                CFG_ALPHA_THRESHOLD: thresh_next = cfg.data[ALPHA_W-1:0];
                default:             ;
            endcase
        end
        eff_width  = eff_dim(width_reg);
        eff_height = eff_dim(height_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            thresh_reg <= THRESHOLD_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            thresh_reg <= thresh_next;
        end
    end

    abac_track u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .width     (eff_width),
        .height    (eff_height),
        .threshold (thresh_reg),
        .pixel     (pixel),
        .box_valid (box_valid),
        .box       (box),
        .box_ready (box_ready)
    );

    abac_crop u_crop (
        .clk       (clk),
        .rst_n     (rst_n),
        .box_valid (box_valid),
        .box       (box),
        .box_ready (box_ready),
        .result    (result)
    );

    // An empty frame always reports the whole frame from the origin.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.content_found |-> result.crop_x == '0 && result.crop_y == '0)
        else $error("empty frame result not anchored at origin");

    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.crop_width != '0 && result.crop_height != '0)
        else $error("crop rectangle has zero size");

    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |->
            (14'(result.crop_x) + 14'(result.crop_width)) <= 14'(MAX_DIMENSION) &&
            (14'(result.crop_y) + 14'(result.crop_height)) <= 14'(MAX_DIMENSION))
        else $error("crop rectangle extends beyond the largest frame");

    assert property (@(posedge clk) disable iff (!rst_n)
        box_valid && !box_ready |=> box_valid && $stable(box))
        else $error("captured frame box lost while the crop pipeline is stalled");

endmodule
